[src/json_token_lexer_top_assert.svh]
// ----------------------------------------------------------------------------
// JSON token lexer assertion macros
// Shared concurrent assertion forms used by the lexer's port checker.
// ----------------------------------------------------------------------------
`ifndef JSON_TOKEN_LEXER_TOP_ASSERT_SVH
`define JSON_TOKEN_LEXER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define JTL_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("json token lexer assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define JTL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("json token lexer assertion failed");

`endif

[src/jtl_pkg.sv]
// ----------------------------------------------------------------------------
// JSON token lexer package
// Lexer modes, event kinds and the event records passed between modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jtl_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_STR  = 3'd1,
    MODE_ESC  = 3'd2,
    MODE_HEX  = 3'd3,
    MODE_INT  = 3'd4,
    MODE_FLT  = 3'd5,
    MODE_BOOL = 3'd6,
    MODE_NULL = 3'd7
  } mode_t;

  typedef enum logic [3:0] {
    EV_OBJOPEN  = 4'd0,
    EV_OBJCLOSE = 4'd1,
    EV_ARROPEN  = 4'd2,
    EV_ARRCLOSE = 4'd3,
    EV_STRBYTE  = 4'd4,
    EV_STREND   = 4'd5,
    EV_COLON    = 4'd6,
    EV_INT      = 4'd7,
    EV_FLOAT    = 4'd8,
    EV_BOOL     = 4'd9,
    EV_NULL     = 4'd10,
    EV_ERROR    = 4'd11
  } ev_kind_t;

  typedef struct packed {
    ev_kind_t           kind;
    logic signed [63:0] value;
    logic               last;
  } event_t;

  // Events produced by one byte: zero, one or two, slot 0 first.
  typedef struct packed {
    logic [1:0] count;
    event_t     ev0;
    event_t     ev1;
  } push_t;

endpackage

[src/jtl_if.sv]
// ----------------------------------------------------------------------------
// JSON token lexer channels
// Valid/ready interfaces for the byte input and the event output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface jtl_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface jtl_event_if;
  logic               valid;
  logic               ready;
  logic [3:0]         event_kind;
  logic signed [63:0] token_value;
  logic               last_of_run;

  modport source (output valid, output event_kind, output token_value,
                  output last_of_run, input ready);
  modport sink   (input valid, input event_kind, input token_value,
                  input last_of_run, output ready);
endinterface

[src/jtl_lexer_core.sv]
// ----------------------------------------------------------------------------
// JSON token lexer core
// Input byte register, lexer state and the per-byte event decode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jtl_lexer_core (
  input  logic          clk,
  input  logic          rst_n,
  jtl_byte_if.sink      in_ch,
  input  logic          room,
  output jtl_pkg::push_t push
);
  import jtl_pkg::*;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_UE     = 8'h45;
  localparam logic [7:0] CH_LBRK   = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRK   = 8'h5D;
  localparam logic [7:0] CH_LB     = 8'h62;
  localparam logic [7:0] CH_LE     = 8'h65;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_LN     = 8'h6E;
  localparam logic [7:0] CH_LR     = 8'h72;
  localparam logic [7:0] CH_LT     = 8'h74;
  localparam logic [7:0] CH_LU     = 8'h75;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  logic        byte_v_r, byte_v_nxt;
  logic [7:0]  byte_r;
  mode_t       mode_r, mode_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic        neg_r, neg_nxt;
  logic [1:0]  hex_r, hex_nxt;
  logic        boolf_r, boolf_nxt;

  logic        fire;
  logic        accept;
  logic        is_digit;
  logic        tok;
  logic        a_v, b_v;
  ev_kind_t    a_kind, b_kind;
  logic [63:0] a_val;
  logic [63:0] acc_neg;

  assign fire         = byte_v_r && room;
  assign in_ch.ready  = !byte_v_r || room;
  assign accept       = in_ch.valid && in_ch.ready;
  assign is_digit     = byte_r inside {[8'h30:8'h39]};
  assign acc_neg      = 64'd0 - acc_r;

  always_comb begin
    byte_v_nxt = byte_v_r;
    if (accept) begin
      byte_v_nxt = 1'b1;
    end else if (fire) begin
      byte_v_nxt = 1'b0;
    end
  end

  // Mode-specific decode (event a), then the between-tokens handling of the
  // same byte (event b) when the current token ends on it.
  always_comb begin
    mode_nxt  = mode_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    hex_nxt   = hex_r;
    boolf_nxt = boolf_r;
    tok       = 1'b0;
    a_v       = 1'b0;
    a_kind    = EV_ERROR;
    a_val     = 64'd0;
    b_v       = 1'b0;
    b_kind    = EV_ERROR;

    case (mode_r)
      MODE_STR: begin
        if (byte_r == CH_QUOTE) begin
          mode_nxt = MODE_IDLE;
          a_v      = 1'b1;
          a_kind   = EV_STREND;
        end else if (byte_r == CH_BSLASH) begin
          mode_nxt = MODE_ESC;
        end else begin
          a_v    = 1'b1;
          a_kind = EV_STRBYTE;
          a_val  = {56'd0, byte_r};
        end
      end
      MODE_ESC: begin
        a_v    = 1'b1;
        a_kind = EV_STRBYTE;
        if (byte_r == CH_LU) begin
          mode_nxt = MODE_HEX;
          hex_nxt  = 2'd0;
          a_val    = {56'd0, CH_QMARK};
        end else begin
          mode_nxt = MODE_STR;
          case (byte_r)
            CH_LB:   a_val = 64'd8;
            CH_LF:   a_val = 64'd12;
            CH_LN:   a_val = 64'd10;
            CH_LR:   a_val = 64'd13;
            CH_LT:   a_val = 64'd9;
            default: a_val = {56'd0, byte_r};
          endcase
        end
      end
      MODE_HEX: begin
        if (hex_r == 2'd3) begin
          hex_nxt  = 2'd0;
          mode_nxt = MODE_STR;
        end else begin
          hex_nxt = hex_r + 2'd1;
        end
      end
      MODE_INT: begin
        if (is_digit) begin
          acc_nxt = (acc_r << 3) + (acc_r << 1) + {60'd0, byte_r[3:0]};
        end else if (byte_r == CH_DOT || byte_r == CH_LE || byte_r == CH_UE) begin
          mode_nxt = MODE_FLT;
        end else begin
          a_v    = 1'b1;
          a_kind = EV_INT;
          a_val  = neg_r ? acc_neg : acc_r;
          tok    = 1'b1;
        end
      end
      MODE_FLT: begin
        if (!(is_digit || byte_r == CH_DOT || byte_r == CH_LE || byte_r == CH_UE ||
              byte_r == CH_MINUS || byte_r == CH_PLUS)) begin
          a_v    = 1'b1;
          a_kind = EV_FLOAT;
          tok    = 1'b1;
        end
      end
      MODE_BOOL, MODE_NULL: begin
        if (!(byte_r inside {[8'h61:8'h7A]})) begin
          a_v    = 1'b1;
          a_kind = (mode_r == MODE_BOOL) ? EV_BOOL : EV_NULL;
          a_val  = (mode_r == MODE_BOOL) ? {63'd0, boolf_r} : 64'd0;
          tok    = 1'b1;
        end
      end
      default: begin
        tok = 1'b1;
      end
    endcase

    if (tok) begin
      mode_nxt = MODE_IDLE;
      if (byte_r <= CH_SPACE || byte_r == CH_COMMA) begin
        b_v = 1'b0;
      end else begin
        case (byte_r)
          CH_LBRACE: begin b_v = 1'b1; b_kind = EV_OBJOPEN;  end
          CH_RBRACE: begin b_v = 1'b1; b_kind = EV_OBJCLOSE; end
          CH_LBRK:   begin b_v = 1'b1; b_kind = EV_ARROPEN;  end
          CH_RBRK:   begin b_v = 1'b1; b_kind = EV_ARRCLOSE; end
          CH_COLON:  begin b_v = 1'b1; b_kind = EV_COLON;    end
          CH_QUOTE:  mode_nxt = MODE_STR;
          CH_LT, CH_LF: begin
            mode_nxt  = MODE_BOOL;
            boolf_nxt = (byte_r == CH_LT);
          end
          CH_LN:     mode_nxt = MODE_NULL;
          default: begin
            if (byte_r == CH_MINUS || is_digit) begin
              mode_nxt = MODE_INT;
              neg_nxt  = (byte_r == CH_MINUS);
              acc_nxt  = is_digit ? {60'd0, byte_r[3:0]} : 64'd0;
            end else begin
              b_v    = 1'b1;
              b_kind = EV_ERROR;
            end
          end
        endcase
      end
    end
  end

  // Pack the events of this byte; the last one carries last_of_run.
  always_comb begin
    push.count      = fire ? ({1'b0, a_v} + {1'b0, b_v}) : 2'd0;
    push.ev0.kind   = a_v ? a_kind : b_kind;
    push.ev0.value  = a_v ? a_val : 64'd0;
    push.ev0.last   = !(a_v && b_v);
    push.ev1.kind   = b_kind;
    push.ev1.value  = 64'd0;
    push.ev1.last   = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_v_r <= 1'b0;
      mode_r   <= MODE_IDLE;
      acc_r    <= 64'd0;
      neg_r    <= 1'b0;
      hex_r    <= 2'd0;
      boolf_r  <= 1'b0;
    end else begin
      byte_v_r <= byte_v_nxt;
      if (fire) begin
        mode_r  <= mode_nxt;
        acc_r   <= acc_nxt;
        neg_r   <= neg_nxt;
        hex_r   <= hex_nxt;
        boolf_r <= boolf_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_ch.in_byte;
    end
  end

endmodule

[src/jtl_event_fifo.sv]
// ----------------------------------------------------------------------------
// JSON token lexer event queue
// Four-entry result queue: up to two in a cycle, one out a cycle while ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jtl_event_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  jtl_pkg::push_t push,
  output logic           room,
  jtl_event_if.source    out_ch
);
  import jtl_pkg::*;

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  event_t          mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]     count_r, count_nxt;
  logic            pop;
  event_t          head;

  assign room   = (count_r <= (AW+1)'(DEPTH - 2));
  assign pop    = out_ch.valid && out_ch.ready;
  assign head   = mem_r[rd_ptr_r];

  assign out_ch.valid       = (count_r != '0);
  assign out_ch.event_kind  = head.kind;
  assign out_ch.token_value = head.value;
  assign out_ch.last_of_run = head.last;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + AW'(push.count);
    rd_ptr_nxt = rd_ptr_r + AW'(pop);
    count_nxt  = count_r + (AW+1)'(push.count) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem_r[wr_ptr_r] <= push.ev0;
    end
    if (push.count == 2'd2) begin
      mem_r[wr_ptr_r + AW'(1)] <= push.ev1;
    end
  end

endmodule

[src/json_token_lexer_top.sv]
// Reset: synchronous, active low; lexer idle. An accepted byte is held in the
// byte register and decoded; its events are written into the event queue.
// Throughput: one byte per cycle; the byte register and the per-byte decode
// take a new beat every cycle while the four-entry event queue has two free slots.
// A byte that ends a number or word and is itself a token gives two events,
// which leave the queue one per cycle while the consumer is ready.
// ----------------------------------------------------------------------------
// JSON token lexer top level
// Streams JSON text in one byte per beat and emits token events.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module json_token_lexer_top (
  input  logic         clk,
  input  logic         rst_n,
  jtl_byte_if.sink     in_ch,
  jtl_event_if.source  out_ch
);
  import jtl_pkg::*;

  // The core holds the input byte register and the lexer state. Each cycle
  // it decodes the registered byte against the current mode and hands zero,
  // one or two events to the queue. Reset leaves the accumulator and the
  // flags at zero.
  push_t push;

  // The queue reports room when at least two entries are free, so the core
  // never has to split the events of one byte.
  logic  room;

  jtl_lexer_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .room  (room),
    .push  (push)
  );

  // The queue is the result register: it parts the output handshake from
  // the input side, so a stalled consumer does not stop the next beat from
  // being taken until fewer than two queue entries are free.
  jtl_event_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .room   (room),
    .out_ch (out_ch)
  );

endmodule

[src/jtl_checker.sv]
// ----------------------------------------------------------------------------
// JSON token lexer port checker
// Assertions on the event channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "json_token_lexer_top_assert.svh"

module jtl_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [3:0]         out_kind,
  input logic signed [63:0] out_token,
  input logic               out_last
);
  import jtl_pkg::*;

  logic [68:0] out_beat;
  logic        has_value;
  logic        narrow_value;

  assign out_beat     = {out_kind, out_token, out_last};
  assign has_value    = (out_kind == EV_STRBYTE) || (out_kind == EV_INT) ||
                        (out_kind == EV_BOOL);
  assign narrow_value = (out_kind == EV_STRBYTE) || (out_kind == EV_BOOL);

  // A stalled event beat keeps its payload.
  `JTL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_beat))

  // Only defined event kinds come out.
  `JTL_ASSERT_SAME(a_kind_range, out_valid, out_kind <= EV_ERROR)

  // Kinds without a value carry zero.
  `JTL_ASSERT_SAME(a_value_zero, out_valid && !has_value, out_token == 64'sd0)

  // String bytes and bools fit their narrow ranges.
  `JTL_ASSERT_SAME(a_value_narrow, out_valid && narrow_value, out_token[63:8] == 56'd0)

endmodule

bind json_token_lexer_top jtl_checker u_jtl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_kind  (out_ch.event_kind),
  .out_token (out_ch.token_value),
  .out_last  (out_ch.last_of_run)
);

[test/json_token_lexer_top_test.sv]
// ----------------------------------------------------------------------------
// JSON token lexer testbench
// Streams directed and random JSON text into the lexer with random gaps and
// stalls on both channels, predicts every token event in the bench, and
// compares each event leaving the block field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module json_token_lexer_top_test;
  import jtl_pkg::*;

  // Directed rows either trust the lexer model below or carry their answer.
  typedef enum logic [1:0] {
    ROW_PRED = 2'd0,
    ROW_NONE = 2'd1,
    ROW_ONE  = 2'd2
  } row_form_t;

  typedef struct packed {
    logic [7:0]  text;
    row_form_t   form;
    ev_kind_t    kind;
    logic [63:0] value;
  } dir_row_t;

  localparam int RANDOM_BYTES = 480;

  logic clk = 1'b0;
  logic rst_n;

  jtl_byte_if  in_ch ();
  jtl_event_if out_ch ();

  json_token_lexer_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #4 clk = ~clk;

  // Bench copy of the lexer state.
  mode_t       lex_st;
  logic [63:0] int_mag;
  logic        int_neg;
  logic [1:0]  hex_seen;
  logic        word_true;

  // Events caused by the byte being tracked, oldest first.
  ev_kind_t    step_kind [2];
  logic [63:0] step_val [2];
  int          step_n;

  // Override for directed rows whose answer is typed into the table.
  row_form_t   typed_form;
  ev_kind_t    typed_kind;
  logic [63:0] typed_val;

  event_t   events_due [$];
  dir_row_t dir_rows [$];

  int  errors;
  int  bytes_lexed;
  int  events_checked;
  int  kind_hits [16];
  bit  no_gaps;

  function automatic int pick_gap();
    return no_gaps ? 0 : $urandom_range(0, 5);
  endfunction

  function automatic dir_row_t mk_row(logic [7:0] text, row_form_t form,
                                      ev_kind_t kind, logic [63:0] value);
    dir_row_t r;
    r.text  = text;
    r.form  = form;
    r.kind  = kind;
    r.value = value;
    return r;
  endfunction

  function automatic bit is_digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic [7:0] unescape(logic [7:0] b);
    case (b)
      "b":     return 8'd8;
      "f":     return 8'd12;
      "n":     return 8'd10;
      "r":     return 8'd13;
      "t":     return 8'd9;
      default: return b;
    endcase
  endfunction

  task automatic note_event(ev_kind_t kind, logic [63:0] val);
    step_kind[step_n] = kind;
    step_val[step_n]  = val;
    step_n++;
  endtask

  // Handles a byte that arrives between tokens, including the byte that
  // ends a number or a word.
  task automatic lex_between(logic [7:0] b);
    lex_st = MODE_IDLE;
    if (b > " " && b != ",") begin
      case (b)
        "{":  note_event(EV_OBJOPEN, '0);
        "}":  note_event(EV_OBJCLOSE, '0);
        "[":  note_event(EV_ARROPEN, '0);
        "]":  note_event(EV_ARRCLOSE, '0);
        ":":  note_event(EV_COLON, '0);
        "\"": lex_st = MODE_STR;
        "t", "f": begin
          lex_st    = MODE_BOOL;
          word_true = (b == "t");
        end
        "n":  lex_st = MODE_NULL;
        default: begin
          if (b == "-" || is_digit(b)) begin
            lex_st  = MODE_INT;
            int_neg = (b == "-");
            int_mag = is_digit(b) ? {56'd0, b - "0"} : 64'd0;
          end else begin
            note_event(EV_ERROR, '0);
          end
        end
      endcase
    end
  endtask

  // Advances the bench lexer by one byte and leaves its events in step_*.
  // A byte is ignored when it is skipped between tokens.
  task automatic lex_track_byte(logic [7:0] b, output bit ignored);
    bit was_idle;
    was_idle = (lex_st == MODE_IDLE);
    step_n   = 0;
    case (lex_st)
      MODE_STR: begin
        if (b == "\"") begin
          lex_st = MODE_IDLE;
          note_event(EV_STREND, '0);
        end else if (b == "\\") begin
          lex_st = MODE_ESC;
        end else begin
          note_event(EV_STRBYTE, {56'd0, b});
        end
      end
      MODE_ESC: begin
        if (b == "u") begin
          lex_st   = MODE_HEX;
          hex_seen = 2'd0;
          note_event(EV_STRBYTE, {56'd0, 8'h3F});
        end else begin
          lex_st = MODE_STR;
          note_event(EV_STRBYTE, {56'd0, unescape(b)});
        end
      end
      MODE_HEX: begin
        // Four bytes after \u are dropped unseen, quotes included.
        if (hex_seen == 2'd3) begin
          hex_seen = 2'd0;
          lex_st   = MODE_STR;
        end else begin
          hex_seen = hex_seen + 2'd1;
        end
      end
      MODE_INT: begin
        if (is_digit(b)) begin
          int_mag = int_mag * 64'd10 + {56'd0, b - "0"};
        end else if (b == "." || b == "e" || b == "E") begin
          lex_st = MODE_FLT;
        end else begin
          note_event(EV_INT, int_neg ? -int_mag : int_mag);
          lex_between(b);
        end
      end
      MODE_FLT: begin
        if (!(is_digit(b) || b == "." || b == "e" || b == "E" || b == "-" ||
              b == "+")) begin
          note_event(EV_FLOAT, '0);
          lex_between(b);
        end
      end
      MODE_BOOL, MODE_NULL: begin
        if (!(b >= "a" && b <= "z")) begin
          if (lex_st == MODE_BOOL) begin
            note_event(EV_BOOL, {63'd0, word_true});
          end else begin
            note_event(EV_NULL, '0);
          end
          lex_between(b);
        end
      end
      default: begin
        lex_between(b);
      end
    endcase
    ignored = was_idle && lex_st == MODE_IDLE && step_n == 0;
  endtask

  // Offers one byte after a random gap, waits for the beat, and files the
  // events it causes. Called and returns at a falling edge.
  task automatic send_byte(logic [7:0] b);
    int     gap;
    int     k;
    bit     ignored;
    event_t ev;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    lex_track_byte(b, ignored);
    if (typed_form != ROW_PRED) begin
      step_n       = (typed_form == ROW_ONE) ? 1 : 0;
      step_kind[0] = typed_kind;
      step_val[0]  = typed_val;
    end
    for (k = 0; k < step_n; k++) begin
      ev.kind  = step_kind[k];
      ev.value = step_val[k];
      ev.last  = (k == step_n - 1);
      events_due.push_back(ev);
    end
    if (!ignored) bytes_lexed++;
    @(negedge clk);
  endtask

  task automatic send_text(string s);
    int k;
    for (k = 0; k < s.len(); k++) send_byte(s[k]);
  endtask

  // A quoted string with plain bytes of any value but quote and backslash,
  // short escapes and unicode escapes; now and then the closing quote is left off.
  task automatic emit_string();
    string      esc_set;
    string      hex_set;
    logic [7:0] c;
    esc_set = "bfnrt\"\\/aZu";
    hex_set = "0123456789abcdefABCDEF";
    send_byte("\"");
    repeat ($urandom_range(0, 8)) begin
      case ($urandom_range(0, 7))
        0: begin
          send_byte("\\");
          send_byte(esc_set[$urandom_range(0, esc_set.len() - 1)]);
        end
        1: begin
          send_byte("\\");
          send_byte("u");
          repeat (4) begin
            if ($urandom_range(0, 3) == 0) begin
              c = 8'($urandom_range(0, 255));
            end else begin
              c = hex_set[$urandom_range(0, hex_set.len() - 1)];
            end
            send_byte(c);
          end
        end
        default: begin
          c = 8'($urandom_range(0, 255));
          if (c == "\"" || c == "\\") c = "_";
          send_byte(c);
        end
      endcase
    end
    if ($urandom_range(0, 15) != 0) send_byte("\"");
  endtask

  // Mostly short integers; sometimes long ones that wrap, the signed and
  // unsigned extremes, or a float tail.
  task automatic emit_number();
    string flt_set;
    flt_set = "0123456789.eE-+";
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 4))
        0: send_text("9223372036854775807");
        1: send_text("-9223372036854775808");
        2: send_text("18446744073709551615");
        3: send_text("18446744073709551616");
        default: send_text("-0");
      endcase
    end else begin
      if ($urandom_range(0, 2) == 0) send_byte("-");
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(4, 24) :
              $urandom_range(1, 3)) begin
        send_byte(8'("0" + $urandom_range(0, 9)));
      end
      if ($urandom_range(0, 3) == 0) begin
        send_byte(flt_set[$urandom_range(10, 12)]);
        repeat ($urandom_range(0, 4)) send_byte(flt_set[$urandom_range(0, 14)]);
      end
    end
  endtask

  task automatic emit_word();
    string lead_set;
    lead_set = "tfn";
    case ($urandom_range(0, 3))
      0: send_text("true");
      1: send_text("false");
      2: send_text("null");
      default: begin
        send_byte(lead_set[$urandom_range(0, 2)]);
        repeat ($urandom_range(0, 6)) send_byte(8'("a" + $urandom_range(0, 25)));
      end
    endcase
  endtask

  // Runs out of stimulus time if the lexer stops answering.
  initial begin
    #2_000_000;
    $display("json_token_lexer_top_test: errors");
    $finish;
  end

  // Event side: stall at random, then take one beat and check it against
  // the oldest predicted event.
  initial begin
    int     stall;
    event_t want;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      events_checked++;
      if (!$isunknown(out_ch.event_kind)) kind_hits[out_ch.event_kind]++;
      if (events_due.size() == 0) begin
        errors++;
        $display("%0t: event with none predicted: kind %0d value %0d last %0b",
                 $time, out_ch.event_kind, out_ch.token_value, out_ch.last_of_run);
      end else begin
        want = events_due.pop_front();
        if (out_ch.event_kind !== want.kind) begin
          errors++;
          $display("%0t: event_kind expected %0d, got %0d",
                   $time, want.kind, out_ch.event_kind);
        end
        if (out_ch.token_value !== want.value) begin
          errors++;
          $display("%0t: token_value expected %0d, got %0d",
                   $time, want.value, out_ch.token_value);
        end
        if (out_ch.last_of_run !== want.last) begin
          errors++;
          $display("%0t: last_of_run expected %0b, got %0b",
                   $time, want.last, out_ch.last_of_run);
        end
      end
      @(negedge clk);
    end
  end

  // Byte side: reset, the directed table, a drain pause, then random text.
  initial begin
    dir_row_t   row;
    logic [7:0] c;
    string      struct_set;
    struct_set     = "{}[]:,";
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.in_byte  = 8'd0;
    lex_st         = MODE_IDLE;
    int_mag        = 64'd0;
    int_neg        = 1'b0;
    hex_seen       = 2'd0;
    word_true      = 1'b0;
    typed_form     = ROW_PRED;
    typed_kind     = EV_ERROR;
    typed_val      = 64'd0;
    no_gaps        = 1'b0;
    errors         = 0;
    bytes_lexed    = 0;
    events_checked = 0;
    foreach (kind_hits[k]) kind_hits[k] = 0;

    // Skipped control byte, top byte value as an unknown token, a string with
    // a control byte, a short escape, a unicode escape whose skipped digits
    // hold quotes, and a pass-through escape; then a lone minus, a float
    // ended by a bracket, a misspelled false ended by a brace, and a null.
    dir_rows.push_back(mk_row(8'h00, ROW_NONE, EV_ERROR, '0));
    dir_rows.push_back(mk_row("{",   ROW_ONE,  EV_OBJOPEN, '0));
    dir_rows.push_back(mk_row(8'hFF, ROW_ONE,  EV_ERROR, '0));
    dir_rows.push_back(mk_row("\"",  ROW_NONE, EV_ERROR, '0));
    dir_rows.push_back(mk_row(8'h01, ROW_PRED, EV_ERROR, '0));
    dir_rows.push_back(mk_row("\\",  ROW_PRED, EV_ERROR, '0));
    dir_rows.push_back(mk_row("n",   ROW_PRED, EV_ERROR, '0));
    dir_rows.push_back(mk_row("\\",  ROW_PRED, EV_ERROR, '0));
    dir_rows.push_back(mk_row("u",   ROW_PRED, EV_ERROR, '0));
    dir_rows.push_back(mk_row("\"",  ROW_PRED, EV_ERROR, '0));
    dir_rows.push_back(mk_row("0",   ROW_PRED, EV_ERROR, '0));
    dir_rows.push_back(mk_row("\"",  ROW_PRED, EV_ERROR, '0));
    dir_rows.push_back(mk_row("F",   ROW_PRED, EV_ERROR, '0));
    dir_rows.push_back(mk_row("\\",  ROW_PRED, EV_ERROR, '0));
    dir_rows.push_back(mk_row("/",   ROW_PRED, EV_ERROR, '0));
    dir_rows.push_back(mk_row("\"",  ROW_PRED, EV_ERROR, '0));
    dir_rows.push_back(mk_row(":",   ROW_ONE,  EV_COLON, '0));
    dir_rows.push_back(mk_row("-",   ROW_PRED, EV_ERROR, '0));
    dir_rows.push_back(mk_row(",",   ROW_PRED, EV_ERROR, '0));
    dir_rows.push_back(mk_row("[",   ROW_ONE,  EV_ARROPEN, '0));
    dir_rows.push_back(mk_row("7",   ROW_PRED, EV_ERROR, '0));
    dir_rows.push_back(mk_row("E",   ROW_PRED, EV_ERROR, '0));
    dir_rows.push_back(mk_row("]",   ROW_PRED, EV_ERROR, '0));
    dir_rows.push_back(mk_row("f",   ROW_PRED, EV_ERROR, '0));
    dir_rows.push_back(mk_row("x",   ROW_PRED, EV_ERROR, '0));
    dir_rows.push_back(mk_row("}",   ROW_PRED, EV_ERROR, '0));
    dir_rows.push_back(mk_row("n",   ROW_PRED, EV_ERROR, '0));
    dir_rows.push_back(mk_row(" ",   ROW_PRED, EV_ERROR, '0));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[k]) begin
      row        = dir_rows[k];
      typed_form = row.form;
      typed_kind = row.kind;
      typed_val  = row.value;
      send_byte(row.text);
    end
    typed_form = ROW_PRED;

    // Hold the byte side off until every directed event has left the block.
    in_ch.valid <= 1'b0;
    while (events_due.size() != 0) @(posedge clk);
    @(negedge clk);

    // Random part: mostly well-formed tokens with random content, some
    // structure and whitespace, and raw noise bytes. Gaps switch off for
    // stretches now and then.
    while (bytes_lexed < dir_rows.size() + RANDOM_BYTES) begin
      if ($urandom_range(0, 39) == 0) no_gaps = !no_gaps;
      case ($urandom_range(0, 9))
        0, 1: emit_string();
        2, 3: emit_number();
        4:    emit_word();
        5, 6: send_byte(struct_set[$urandom_range(0, struct_set.len() - 1)]);
        7, 8: begin
          c = 8'($urandom_range(0, 32));
          send_byte(c);
        end
        default: begin
          c = 8'($urandom_range(0, 255));
          send_byte(c);
        end
      endcase
    end

    in_ch.valid <= 1'b0;
    while (events_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("Run covered %0d lexed bytes and %0d checked events.",
             bytes_lexed, events_checked);
    $display("Among them %0d string bytes, %0d ints, %0d floats, %0d bools, %0d nulls, %0d errors.",
             kind_hits[EV_STRBYTE], kind_hits[EV_INT], kind_hits[EV_FLOAT],
             kind_hits[EV_BOOL], kind_hits[EV_NULL], kind_hits[EV_ERROR]);
    if (errors == 0 && events_due.size() == 0) begin
      $display("json_token_lexer_top_test: clean");
    end else begin
      $display("json_token_lexer_top_test: errors");
    end
    $finish;
  end

endmodule
